[design/ptrm_pkg.sv]
// ----------------------------------------------------------------------------
// ptrm_pkg
// Shared constants and controller/datapath handshake types for the
// page table range mapper.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  // table page pool size and derived widths
  localparam int TABLE_PAGES = 16;
  localparam int ENTRIES     = 512;
  localparam int IDX_W       = 9;
  localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
  localparam int ADDR_W      = PAGE_W + IDX_W;
  localparam int DEPTH       = TABLE_PAGES * ENTRIES;

  // field widths
  localparam int VA_W   = 48;
  localparam int LEN_W  = 49;
  localparam int DESC_W = 64;
  localparam int PPN_W  = 36;
  localparam int STAT_W = 2;
  localparam int TIU_W  = 5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_BLK  = 2'd1;
  localparam logic [STAT_W-1:0] ST_POOL_OUT = 2'd2;

  // descriptor type codes
  localparam logic [1:0] DT_BLOCK = 2'b01;
  localparam logic [1:0] DT_TABLE = 2'b11;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic calc;
    logic rd;
    logic cap;
    logic blk_wr;
    logic zero;
    logic alloc_wr;
    logic descend;
    logic leaf_wr;
    logic clear;
    logic set_bad;
    logic set_full;
    logic out_load;
  } ptrm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;
    logic zero_last;
    logic len_done;
    logic e_block;
    logic e_table;
    logic can_block;
    logic pool_full;
    logic rel_bad;
    logic last_lvl;
    logic out_busy;
  } ptrm_sts_t;

endpackage

[design/ptrm_req_if.sv]
// ----------------------------------------------------------------------------
// ptrm_req_if
// Map request channel: valid/ready with the request payload.
// ----------------------------------------------------------------------------
interface ptrm_req_if;
  logic        valid;
  logic        ready;
  logic [47:0] virt_addr;
  logic [47:0] phys_addr;
  logic [48:0] length;
  logic [63:0] attr_flags;

  modport source (output valid, virt_addr, phys_addr, length, attr_flags, input ready);
  modport sink   (input valid, virt_addr, phys_addr, length, attr_flags, output ready);
endinterface

[design/ptrm_rsp_if.sv]
// ----------------------------------------------------------------------------
// ptrm_rsp_if
// Map result channel: valid/ready with status and table count.
// ----------------------------------------------------------------------------
interface ptrm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] tables_in_use;

  modport source (output valid, status, tables_in_use, input ready);
  modport sink   (input valid, status, tables_in_use, output ready);
endinterface

[design/ptrm_ram.sv]
// ----------------------------------------------------------------------------
// ptrm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptrm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ptrm_datapath.sv]
// ----------------------------------------------------------------------------
// ptrm_datapath
// Request registers, walk address math, descriptor build and table store.
// ----------------------------------------------------------------------------
module ptrm_datapath
  import ptrm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ptrm_cmd_t           cmd,
  output ptrm_sts_t           sts,
  input  logic                cfg_we,
  input  logic [PPN_W-1:0]    cfg_wdata,
  input  logic [VA_W-1:0]     in_va,
  input  logic [VA_W-1:0]     in_pa,
  input  logic [LEN_W-1:0]    in_len,
  input  logic [DESC_W-1:0]   in_fl,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   out_status,
  output logic [TIU_W-1:0]    out_tiu
);

  logic [PPN_W-1:0]  pool_base;
  logic [VA_W-1:0]   va, pa, cva, cpa;
  logic [LEN_W-1:0]  len;
  logic [LEN_W:0]    off;
  logic [DESC_W-1:0] fl, e;
  logic [STAT_W-1:0] status;
  logic [NFP_W-1:0]  nfp;
  logic [PAGE_W-1:0] tbl;
  logic [1:0]        lvl;
  logic              fit1, fit2;
  logic [ADDR_W-1:0] clr_cnt;
  logic [IDX_W-1:0]  zcnt;

  logic [DESC_W-1:0] rdata, wdata;
  logic [ADDR_W-1:0] waddr, slot;
  logic              we;
  logic [IDX_W-1:0]  idx;
  logic [PPN_W-1:0]  rel, new_ppn;
  logic [VA_W-1:0]   cva_c, cpa_c;
  logic [LEN_W-1:0]  rem_c;
  logic [8:0]        nfp_w;

  // slot index for the current level
  always_comb begin
    case (lvl)
      2'd0:    idx = cva[47:39];
      2'd1:    idx = cva[38:30];
      2'd2:    idx = cva[29:21];
      default: idx = cva[20:12];
    endcase
  end
  assign slot    = {tbl, idx};
  assign new_ppn = pool_base + PPN_W'(nfp);
  assign rel     = e[47:12] - pool_base;
  assign cva_c   = va + off[VA_W-1:0];
  assign cpa_c   = pa + off[VA_W-1:0];
  assign rem_c   = len - off[LEN_W-1:0];

  // store write select
  always_comb begin
    we    = 1'b1;
    waddr = slot;
    wdata = '0;
    if (cmd.clear) begin
      waddr = clr_cnt;
    end else if (cmd.zero) begin
      waddr = {nfp[PAGE_W-1:0], zcnt};
    end else if (cmd.blk_wr) begin
      if (lvl == 2'd1) begin
        wdata = {16'd0, cpa[47:30], 30'd0} | fl | 64'(DT_BLOCK);
      end else begin
        wdata = {16'd0, cpa[47:21], 21'd0} | fl | 64'(DT_BLOCK);
      end
    end else if (cmd.alloc_wr) begin
      wdata = {16'd0, new_ppn, 10'd0, DT_TABLE};
    end else if (cmd.leaf_wr) begin
      wdata = {16'd0, cpa[47:12], 12'd0} | fl | 64'(DT_TABLE);
    end else begin
      we = 1'b0;
    end
  end

  ptrm_ram #(.WIDTH(DESC_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (slot),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      nfp       <= NFP_W'(1);
      clr_cnt   <= '0;
      zcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        pool_base <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.zero) begin
        zcnt <= zcnt + 1'b1;
      end
      if (cmd.alloc_wr) begin
        nfp <= nfp + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va     <= in_va;
      pa     <= in_pa;
      len    <= in_len;
      fl     <= in_fl;
      off    <= '0;
      status <= ST_OK;
    end
    if (cmd.calc) begin
      cva  <= cva_c;
      cpa  <= cpa_c;
      fit1 <= (cva_c[29:0] == '0) && (cpa_c[29:0] == '0) && (rem_c >= LEN_W'(1 << 30));
      fit2 <= (cva_c[20:0] == '0) && (cpa_c[20:0] == '0) && (rem_c >= LEN_W'(1 << 21));
      lvl  <= 2'd0;
      tbl  <= '0;
    end
    if (cmd.cap) begin
      e <= rdata;
    end
    if (cmd.alloc_wr) begin
      e <= {16'd0, new_ppn, 10'd0, DT_TABLE};
    end
    if (cmd.descend) begin
      tbl <= rel[PAGE_W-1:0];
      lvl <= lvl + 1'b1;
    end
    if (cmd.blk_wr) begin
      off <= off + ((lvl == 2'd1) ? (LEN_W+1)'(1 << 30) : (LEN_W+1)'(1 << 21));
    end
    if (cmd.leaf_wr) begin
      off <= off + (LEN_W+1)'(1 << 12);
    end
    if (cmd.set_bad) begin
      status <= ST_BAD_BLK;
    end
    if (cmd.set_full) begin
      status <= ST_POOL_OUT;
    end
    if (cmd.out_load) begin
      out_status <= status;
      out_tiu    <= nfp_w[TIU_W-1:0];
    end
  end

  assign nfp_w = 9'(nfp);

  // status to controller
  always_comb begin
    sts.clear_last = (clr_cnt == ADDR_W'(DEPTH - 1));
    sts.zero_last  = (zcnt == IDX_W'(ENTRIES - 1));
    sts.len_done   = (off >= {1'b0, len});
    sts.e_block    = (e[1:0] == DT_BLOCK);
    sts.e_table    = (e[1:0] == DT_TABLE);
    sts.can_block  = ((lvl == 2'd1) && fit1) || ((lvl == 2'd2) && fit2);
    sts.pool_full  = (nfp >= NFP_W'(TABLE_PAGES));
    sts.rel_bad    = (rel >= PPN_W'(TABLE_PAGES));
    sts.last_lvl   = (lvl == 2'd2);
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

[design/ptrm_ctrl.sv]
// ----------------------------------------------------------------------------
// ptrm_ctrl
// Walk sequencer: store clear, per-step level walk, allocation and result.
// ----------------------------------------------------------------------------
module ptrm_ctrl
  import ptrm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ptrm_sts_t sts,
  output ptrm_cmd_t cmd,
  input  logic      in_valid,
  output logic      in_ready
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_RD    = 11'b000_0000_1000,
    S_WT    = 11'b000_0001_0000,
    S_EVAL  = 11'b000_0010_0000,
    S_ZERO  = 11'b000_0100_0000,
    S_ALLOC = 11'b000_1000_0000,
    S_REL   = 11'b001_0000_0000,
    S_LEAF  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.len_done) begin
          state_next = S_DONE;
        end else begin
          cmd.calc   = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WT;
      end
      S_WT: begin
        cmd.cap    = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (sts.e_block) begin
          cmd.set_bad = 1'b1;
          state_next  = S_DONE;
        end else if (sts.e_table) begin
          state_next = S_REL;
        end else if (sts.can_block) begin
          cmd.blk_wr = 1'b1;
          state_next = S_CHECK;
        end else if (sts.pool_full) begin
          cmd.set_full = 1'b1;
          state_next   = S_DONE;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.zero = 1'b1;
        if (sts.zero_last) state_next = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_REL;
      end
      S_REL: begin
        if (sts.rel_bad) begin
          cmd.set_bad = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.descend = 1'b1;
          state_next  = sts.last_lvl ? S_LEAF : S_RD;
        end
      end
      S_LEAF: begin
        cmd.leaf_wr = 1'b1;
        state_next  = S_CHECK;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[design/page_table_range_mapper_top.sv]
// ----------------------------------------------------------------------------
// page_table_range_mapper_top
// Builds a four-level 4K-granule translation table over a pool of table
// pages, one map request at a time, one status result per request.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      contents
//  req       in    valid/ready    virt_addr, phys_addr, length, attr_flags
//  rsp       out   valid/ready    status, tables_in_use
//  cfg       in    cfg_we         cfg_wdata = pool_base_page
//
//  After reset the table store is swept to zero, one entry a cycle, all
//  TABLE_PAGES*512 entries (8192) with req.ready low.
//  Each mapped step runs S_CHECK, then S_RD, S_WT, S_EVAL and S_REL per table
//  level walked, then one write: a 4K page from S_LEAF, or a 1GB or 2MB block
//  from S_EVAL. Each new table page adds a sweep zeroing its 512 entries through
//  the single store write port, then the table descriptor write.
//  A request is taken only when the walker is idle; a result waiting on rsp
//  holds the walker in its last state until the previous result moves.
// ----------------------------------------------------------------------------
module page_table_range_mapper_top
  import ptrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ptrm_req_if.sink    req,
  ptrm_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [35:0] cfg_wdata
);

  ptrm_cmd_t cmd;
  ptrm_sts_t sts;

  // sequencer
  ptrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sts      (sts),
    .cmd      (cmd),
    .in_valid (req.valid),
    .in_ready (req.ready)
  );

  // datapath and table store
  ptrm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_va      (req.virt_addr),
    .in_pa      (req.phys_addr),
    .in_len     (req.length),
    .in_fl      (req.attr_flags),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_status (rsp.status),
    .out_tiu    (rsp.tables_in_use)
  );

endmodule
